// ----- design/two_sat_solver_core_assert.svh -----
// Assertion macros used by the solver core.
`ifndef TWO_SAT_SOLVER_CORE_ASSERT_SVH
`define TWO_SAT_SOLVER_CORE_ASSERT_SVH

// Implication checked every cycle outside reset.
`define TSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/tss_pkg.sv -----
package tss_pkg;
  localparam int unsigned MaxVars = 1024;
  localparam int unsigned MaxClauses = 2048;
  localparam int unsigned EdgeCap = 2 * MaxClauses;
  localparam int unsigned LitCap = 2 * MaxVars;
  localparam int unsigned VarW = $clog2(MaxVars);
  localparam int unsigned LitW = $clog2(LitCap);
  localparam int unsigned EdgeW = $clog2(EdgeCap) + 1;
  localparam int unsigned CntW = VarW + 1;

  typedef logic [1:0] val_t;
  localparam val_t ValFalse = 2'd0;
  localparam val_t ValTrue = 2'd1;
  localparam val_t ValUnset = 2'd2;
endpackage

// ----- design/two_sat_solver_core.sv -----
// two_sat_solver_core: 2-SAT solver with per-variable limited backtracking.
// A clause transaction is taken at a rising edge with start_i high and busy_o
// low. A clause that is kept holds busy_o high while its two implication edges
// are appended (S_LD_A to S_LD_D), so no new clause is taken before they are
// written; a dropped clause that is not the last leaves busy_o low.
// The config write (num_vars_we_i) sets the variable count; it is clamped to
// 1..1024 and should only change while busy_o is low.
// The clause with last_clause_i set is loaded, if kept, and then starts the solve.
// The solve walks the implication graph held in on-chip memories, so its
// length depends on the graph: on the variables scanned, the edges followed,
// the stack pops and the assignments undone. An unsatisfiable result is
// registered and appears in the cycle after the deciding conflict. Otherwise
// the assignment is read out in words of 32 variables, each word valid on
// result_valid_o for a single cycle, the last one marked by last_word_o.
// After the results the block clears its literal and variable stores, one
// entry a cycle, before taking a new clause. Reset starts the same clearing
// pass. Results cannot be stalled.
module two_sat_solver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        num_vars_we_i,
  input  logic [10:0] num_vars_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        neg_a_i,
  input  logic [9:0]  var_a_i,
  input  logic        neg_b_i,
  input  logic [9:0]  var_b_i,
  input  logic        last_clause_i,
  output logic        result_valid_o,
  output logic        satisfiable_o,
  output logic [4:0]  word_index_o,
  output logic [31:0] assignment_bits_o,
  output logic        last_word_o
);
  localparam int unsigned VW = tss_pkg::VarW;
  localparam int unsigned LW = tss_pkg::LitW;
  localparam int unsigned EW = tss_pkg::EdgeW;
  localparam int unsigned CW = tss_pkg::CntW;
  localparam logic [EW-1:0] EdgeNone = EW'(tss_pkg::EdgeCap);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LD_A, S_LD_B, S_LD_C, S_LD_D,
    S_VAR, S_VAR_R, S_VISIT, S_VISIT_R, S_VISIT_H, S_TOP, S_TOP_R, S_EDGE,
    S_EDGE_R, S_UNDO, S_UNDO_R, S_OUT, S_OUT_R, S_DONE
  } state_e;

  state_e state_q;
  logic [10:0] num_vars_q;
  logic [CW-1:0] vars_act;

  // Memories.
  logic [LW-1:0] etgt_mem [tss_pkg::EdgeCap];
  logic [EW-1:0] enext_mem [tss_pkg::EdgeCap];
  logic [EW-1:0] head_mem [tss_pkg::LitCap];
  logic [EW-1:0] tail_mem [tss_pkg::LitCap];
  tss_pkg::val_t val_mem [tss_pkg::MaxVars];
  logic [1:0] seen_mem [tss_pkg::MaxVars];
  logic [VW-1:0] trail_mem [tss_pkg::MaxVars];
  logic [LW-1:0] stk_lit_mem [tss_pkg::MaxVars];
  logic [EW-1:0] stk_edge_mem [tss_pkg::MaxVars];

  logic [LW-1:0] etgt_rd;
  logic [EW-1:0] enext_rd, head_rd, tail_rd, stk_edge_rd;
  tss_pkg::val_t val_rd;
  logic [1:0] seen_rd;
  logic [VW-1:0] trail_rd;
  logic [LW-1:0] stk_lit_rd;

  // Control registers.
  logic [EW-1:0] ecnt_q, cur_e_q;
  logic [CW-1:0] tcnt_q, scnt_q, vi_q;
  logic [LW-1:0] clr_q;
  logic [LW-1:0] lit_q, la_q, lb_q;
  logic single_q, second_q, last_q;
  logic [4:0] w_q;
  logic [31:0] bits_q;
  logic rv_q, rsat_q, rlast_q;
  logic [4:0] rw_q;
  logic [31:0] rbits_q;

  // The next pointer of the old tail is written in the cycle after the new
  // edge, in a state where the append port is idle.
  logic link_we_q;
  logic [EW-1:0] link_a_q, link_d_q;

  // Memory ports driven by the state machine.
  logic hd_we, tl_we, et_we, en_we, va_we, se_we, tr_we, sk_we;
  logic [LW-1:0] hd_wa, tl_wa, hd_ra, sk_lit_wd;
  logic [EW-1:0] hd_wd, tl_wd, en_wd, sk_edge_wd, e_wa, e_ra;
  logic [LW-1:0] et_wd;
  logic [VW-1:0] va_wa, va_ra, se_wa, se_ra, tr_wa, tr_ra, tr_wd, sk_a, sk_ra;
  tss_pkg::val_t va_wd;
  logic [1:0] se_wd;

  always_ff @(posedge clk_i) begin
    if (hd_we) head_mem[hd_wa] <= hd_wd;
    head_rd <= head_mem[hd_ra];
    if (tl_we) tail_mem[tl_wa] <= tl_wd;
    tail_rd <= tail_mem[hd_ra];
    if (et_we) etgt_mem[e_wa[EW-2:0]] <= et_wd;
    etgt_rd <= etgt_mem[e_ra[EW-2:0]];
    if (en_we) enext_mem[e_wa[EW-2:0]] <= en_wd;
    else if (link_we_q) enext_mem[link_a_q[EW-2:0]] <= link_d_q;
    enext_rd <= enext_mem[e_ra[EW-2:0]];
    if (va_we) val_mem[va_wa] <= va_wd;
    val_rd <= val_mem[va_ra];
    if (se_we) seen_mem[se_wa] <= se_wd;
    seen_rd <= seen_mem[se_ra];
    if (tr_we) trail_mem[tr_wa] <= tr_wd;
    trail_rd <= trail_mem[tr_ra];
    if (sk_we) begin
      stk_lit_mem[sk_a] <= sk_lit_wd;
      stk_edge_mem[sk_a] <= sk_edge_wd;
    end
    stk_lit_rd <= stk_lit_mem[sk_ra];
    stk_edge_rd <= stk_edge_mem[sk_ra];
  end

  // Helpers.
  logic [LW-1:0] in_la, in_lb;
  logic in_ok;
  logic [VW-1:0] lit_var;
  logic lit_want;
  assign in_la = {neg_a_i, var_a_i};
  assign in_lb = {neg_b_i, var_b_i};
  assign in_ok = ({1'b0, var_a_i} < vars_act) && ({1'b0, var_b_i} < vars_act)
                 && (ecnt_q <= EW'(tss_pkg::EdgeCap - 2));
  assign lit_var = lit_q[VW-1:0];
  assign lit_want = ~lit_q[LW-1];

  // Loading: S_LD_A/B append not-a -> b, S_LD_C/D append not-b -> a.
  logic [LW-1:0] from_lit, to_lit;
  logic first_edge;
  assign first_edge = (state_q == S_LD_A || state_q == S_LD_B);
  assign from_lit = first_edge ? {~la_q[LW-1], la_q[VW-1:0]}
                               : {~lb_q[LW-1], lb_q[VW-1:0]};
  assign to_lit = first_edge ? lb_q : la_q;

  logic conflict;
  assign conflict = (val_rd == tss_pkg::ValFalse && lit_want)
                    || (val_rd == tss_pkg::ValTrue && !lit_want);

  always_comb begin
    hd_we = 1'b0; tl_we = 1'b0; et_we = 1'b0; en_we = 1'b0;
    va_we = 1'b0; se_we = 1'b0; tr_we = 1'b0; sk_we = 1'b0;
    hd_wa = from_lit; tl_wa = from_lit; hd_ra = from_lit;
    hd_wd = ecnt_q; tl_wd = ecnt_q; en_wd = EdgeNone; et_wd = to_lit;
    e_wa = ecnt_q; e_ra = cur_e_q;
    va_wa = lit_var; va_ra = lit_var; va_wd = lit_want ? tss_pkg::ValTrue : tss_pkg::ValFalse;
    se_wa = la_q[VW-1:0]; se_ra = la_q[VW-1:0]; se_wd = 2'b00;
    tr_wa = tcnt_q[VW-1:0]; tr_ra = tcnt_q[VW-1:0] - VW'(1); tr_wd = lit_var;
    sk_a = scnt_q[VW-1:0]; sk_ra = scnt_q[VW-1:0] - VW'(1);
    sk_lit_wd = lit_q; sk_edge_wd = head_rd;
    case (state_q)
      S_CLEAR: begin
        hd_we = 1'b1; hd_wa = clr_q; hd_wd = EdgeNone;
        tl_we = 1'b1; tl_wa = clr_q; tl_wd = EdgeNone;
        va_we = 1'b1; va_wa = clr_q[VW-1:0]; va_wd = tss_pkg::ValUnset;
        se_we = 1'b1; se_wa = clr_q[VW-1:0]; se_wd = 2'b00;
      end
      S_IDLE: begin
        se_ra = var_a_i;
      end
      S_LD_A, S_LD_C: begin
        // Read head/tail of from literal; in S_LD_A also mark polarity of a.
        se_ra = lb_q[VW-1:0];
        if (state_q == S_LD_A) begin
          se_we = 1'b1; se_wa = la_q[VW-1:0];
          se_wd = seen_rd | (la_q[LW-1] ? 2'b10 : 2'b01);
        end
      end
      S_LD_B, S_LD_D: begin
        // Append edge ecnt_q using the head/tail just read.
        et_we = 1'b1; en_we = 1'b1;
        tl_we = 1'b1;
        if (head_rd == EdgeNone) hd_we = 1'b1;
        else begin
          en_we = 1'b1;
        end
        if (state_q == S_LD_B) begin
          // Polarity of b, read in S_LD_A while a's mark was being written,
          // so a's mark is merged in when both name the same variable.
          se_we = 1'b1; se_wa = lb_q[VW-1:0];
          se_wd = seen_rd | (lb_q[LW-1] ? 2'b10 : 2'b01);
          if (lb_q[VW-1:0] == la_q[VW-1:0])
            se_wd = se_wd | (la_q[LW-1] ? 2'b10 : 2'b01);
        end
      end
      S_VAR: begin
        va_ra = vi_q[VW-1:0]; se_ra = vi_q[VW-1:0];
      end
      S_VISIT: begin
        hd_ra = lit_q;
      end
      S_VISIT_R: begin
        hd_ra = lit_q;
        if (!conflict && val_rd == tss_pkg::ValUnset) begin
          va_we = 1'b1; tr_we = 1'b1;
        end
      end
      S_VISIT_H: begin
        sk_we = 1'b1;
      end
      S_EDGE: begin
        sk_we = 1'b1; sk_a = scnt_q[VW-1:0] - VW'(1);
        sk_lit_wd = stk_lit_rd; sk_edge_wd = enext_rd;
      end
      S_UNDO_R: begin
        va_we = 1'b1; va_wa = trail_rd; va_wd = tss_pkg::ValUnset;
      end
      S_OUT: begin
        va_ra = vi_q[VW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      num_vars_q <= 11'd1;
      clr_q <= '0;
      ecnt_q <= '0; tcnt_q <= '0; scnt_q <= '0; vi_q <= '0;
      rv_q <= 1'b0; link_we_q <= 1'b0; last_q <= 1'b0;
      single_q <= 1'b0; second_q <= 1'b0;
    end else begin
      if (num_vars_we_i) num_vars_q <= num_vars_i;
      rv_q <= 1'b0;
      link_we_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LW'(tss_pkg::LitCap - 1)) begin
            state_q <= S_IDLE;
            ecnt_q <= '0; tcnt_q <= '0; scnt_q <= '0;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            la_q <= in_la; lb_q <= in_lb; last_q <= last_clause_i;
            state_q <= in_ok ? S_LD_A : (last_clause_i ? S_VAR : S_IDLE);
            vi_q <= '0;
          end
        end
        S_LD_A: state_q <= S_LD_B;
        S_LD_B, S_LD_D: begin
          if (head_rd != EdgeNone) begin
            link_we_q <= 1'b1; link_a_q <= tail_rd; link_d_q <= ecnt_q;
          end
          ecnt_q <= ecnt_q + 1'b1;
          if (state_q == S_LD_B) state_q <= S_LD_C;
          else begin
            vi_q <= '0;
            state_q <= last_q ? S_VAR : S_IDLE;
          end
        end
        S_LD_C: state_q <= S_LD_D;
        S_VAR: begin
          if (vi_q == vars_act) begin
            vi_q <= '0; w_q <= '0; bits_q <= '0;
            state_q <= S_OUT;
          end else state_q <= S_VAR_R;
        end
        S_VAR_R: begin
          if (val_rd != tss_pkg::ValUnset) begin
            vi_q <= vi_q + 1'b1; state_q <= S_VAR;
          end else begin
            tcnt_q <= '0; scnt_q <= '0; second_q <= 1'b0;
            single_q <= seen_rd[0] ^ seen_rd[1];
            lit_q <= {(seen_rd == 2'b10), vi_q[VW-1:0]};
            state_q <= S_VISIT;
          end
        end
        S_VISIT: state_q <= S_VISIT_R;
        S_VISIT_R: begin
          if ({1'b0, lit_var} >= vars_act) state_q <= (scnt_q == '0) ? S_VAR : S_TOP;
          else if (conflict) begin
            scnt_q <= '0;
            if (single_q) begin vi_q <= vi_q + 1'b1; state_q <= S_VAR; end
            else if (!second_q) state_q <= S_UNDO;
            else begin
              w_q <= '0; state_q <= S_DONE;
              rv_q <= 1'b1; rsat_q <= 1'b0; rw_q <= '0; rbits_q <= '0; rlast_q <= 1'b1;
            end
          end else if (val_rd != tss_pkg::ValUnset) begin
            state_q <= (scnt_q == '0) ? S_VAR : S_TOP;
          end else begin
            tcnt_q <= tcnt_q + 1'b1;
            state_q <= S_VISIT_H;
          end
          if ({1'b0, lit_var} >= vars_act || !conflict)
            if (scnt_q == '0 && (val_rd != tss_pkg::ValUnset || {1'b0, lit_var} >= vars_act))
              vi_q <= vi_q + 1'b1;
        end
        S_VISIT_H: begin
          scnt_q <= scnt_q + 1'b1; state_q <= S_TOP;
        end
        S_TOP: begin
          if (scnt_q == '0) begin vi_q <= vi_q + 1'b1; state_q <= S_VAR; end
          else state_q <= S_TOP_R;
        end
        S_TOP_R: begin
          if (stk_edge_rd >= ecnt_q || stk_edge_rd >= EdgeNone) begin
            scnt_q <= scnt_q - 1'b1; state_q <= S_TOP;
          end else begin
            cur_e_q <= stk_edge_rd; state_q <= S_EDGE_R;
          end
        end
        S_EDGE_R: state_q <= S_EDGE;
        S_EDGE: begin
          lit_q <= etgt_rd; state_q <= S_VISIT;
        end
        S_UNDO: begin
          if (tcnt_q == '0) begin
            second_q <= 1'b1; lit_q <= {1'b1, vi_q[VW-1:0]}; state_q <= S_VISIT;
          end else state_q <= S_UNDO_R;
        end
        S_UNDO_R: begin
          tcnt_q <= tcnt_q - 1'b1; state_q <= S_UNDO;
        end
        S_OUT: state_q <= S_OUT_R;
        S_OUT_R: begin
          if (vi_q[4:0] == 5'd31 || vi_q + 1'b1 >= vars_act) begin
            rv_q <= 1'b1; rsat_q <= 1'b1; rw_q <= w_q;
            rbits_q <= bits_q | ((vi_q < vars_act && val_rd == tss_pkg::ValTrue)
                                 ? (32'd1 << vi_q[4:0]) : 32'd0);
            rlast_q <= (vi_q + 1'b1 >= vars_act);
            bits_q <= '0; w_q <= w_q + 1'b1;
            state_q <= (vi_q + 1'b1 >= vars_act) ? S_DONE : S_OUT;
          end else begin
            if (vi_q < vars_act && val_rd == tss_pkg::ValTrue) bits_q[vi_q[4:0]] <= 1'b1;
            state_q <= S_OUT;
          end
          vi_q <= vi_q + 1'b1;
        end
        S_DONE: begin
          clr_q <= '0; state_q <= S_CLEAR;
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  always_comb begin
    if (num_vars_q == '0) vars_act = CW'(1);
    else if (num_vars_q > 11'(tss_pkg::MaxVars)) vars_act = CW'(tss_pkg::MaxVars);
    else vars_act = CW'(num_vars_q);
  end

  assign busy_o = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign satisfiable_o = rsat_q;
  assign word_index_o = rw_q;
  assign assignment_bits_o = rbits_q;
  assign last_word_o = rlast_q;

  `include "two_sat_solver_core_assert.svh"
  `TSS_ASSERT_IMP(a_res_busy, clk_i, rst_ni, rv_q && !rlast_q, busy_o)
  `TSS_ASSERT_NEXT(a_last_clear, clk_i, rst_ni, rv_q && rlast_q, state_q == S_CLEAR)
  `TSS_ASSERT_IMP(a_unsat_zero, clk_i, rst_ni, rv_q && !rsat_q, rbits_q == '0 && rlast_q)
endmodule
